// ----- hw/rtl/sqr_pkg.sv -----
// Shared types and constants for the stochastic rounding quantizer.
package sqr_pkg;

    localparam int unsigned FLOAT_W = 32;
    localparam int unsigned MANT_W  = 24;
    localparam int unsigned SEED_W  = 64;
    localparam int unsigned DRAW_W  = 24;
    localparam int unsigned ADDR_W  = 6;

    typedef enum logic [2:0]
    {
        REG_STEP  = 3'd0,
        REG_SEED0 = 3'd1,
        REG_SEED1 = 3'd2,
        REG_SEED2 = 3'd3,
        REG_SEED3 = 3'd4
    } sqr_reg_t;

    typedef enum logic [1:0]
    {
        CLS_NAN    = 2'd0,
        CLS_SAT    = 2'd1,
        CLS_ZERO   = 2'd2,
        CLS_FINITE = 2'd3
    } sqr_class_t;

    typedef struct packed
    {
        sqr_class_t               cls;
        logic                     sign;
        logic [MANT_W-1:0]        n_mant;
        logic signed [9:0]        n_exp;
        logic [MANT_W-1:0]        d_mant;
        logic signed [9:0]        d_exp;
        logic [DRAW_W-1:0]        draw;
    } sqr_item_t;

    typedef struct packed
    {
        logic [SEED_W-1:0] w0;
        logic [SEED_W-1:0] w1;
        logic [SEED_W-1:0] w2;
        logic [SEED_W-1:0] w3;
    } sqr_seed_t;

endpackage

// ----- hw/rtl/sqr_front.sv -----
// Front end: takes input words, steps the generator and classifies the operands.
module sqr_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sqr_pkg::FLOAT_W-1:0]   value_bits,
    input  logic                          restart,
    input  logic [sqr_pkg::FLOAT_W-1:0]   step_bits,
    input  sqr_pkg::sqr_seed_t            seeds,
    input  logic                          q_full,
    output logic                          q_push,
    output sqr_pkg::sqr_item_t            q_item
);
    import sqr_pkg::*;

    sqr_seed_t         state_reg;
    sqr_seed_t         state_next;
    sqr_seed_t         base;
    logic [SEED_W-1:0] sum;
    logic [SEED_W-1:0] t2;
    logic [SEED_W-1:0] t3;
    logic [SEED_W-1:0] t1;
    logic [SEED_W-1:0] t0;
    logic              n_nan;
    logic              n_inf;
    logic              n_zero;
    logic              d_nan;
    logic              d_inf;
    logic              d_zero;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        base = restart ? seeds : state_reg;
        sum  = base.w0 + base.w3;
        t2   = base.w2 ^ base.w0;
        t3   = base.w3 ^ base.w1;
        t1   = base.w1 ^ t2;
        t0   = base.w0 ^ t3;
        state_next.w0 = t0;
        state_next.w1 = t1;
        state_next.w2 = t2 ^ (base.w1 << 17);
        state_next.w3 = {t3[18:0], t3[63:19]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{w0: 64'd1, w1: 64'd0, w2: 64'd0, w3: 64'd0};
        end
        else if (q_push)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        n_zero = (value_bits[30:0] == 31'd0);
        n_inf  = (value_bits[30:0] == 31'h7F800000);
        n_nan  = (value_bits[30:0] > 31'h7F800000);
        d_zero = (step_bits[30:0] == 31'd0);
        d_inf  = (step_bits[30:0] == 31'h7F800000);
        d_nan  = (step_bits[30:0] > 31'h7F800000);

        q_item.sign   = value_bits[31] ^ step_bits[31];
        q_item.draw   = sum[63:40];
        q_item.n_mant = {(value_bits[30:23] != 8'd0), value_bits[22:0]};
        q_item.n_exp  = (value_bits[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, value_bits[30:23]});
        q_item.d_mant = {(step_bits[30:23] != 8'd0), step_bits[22:0]};
        q_item.d_exp  = (step_bits[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, step_bits[30:23]});

        if (n_nan || d_nan)
            q_item.cls = CLS_NAN;
        else if (d_zero)
            q_item.cls = n_zero ? CLS_NAN : CLS_SAT;
        else if (d_inf)
            q_item.cls = n_inf ? CLS_NAN : CLS_ZERO;
        else if (n_inf)
            q_item.cls = CLS_SAT;
        else if (n_zero)
            q_item.cls = CLS_ZERO;
        else
            q_item.cls = CLS_FINITE;
    end

endmodule

// ----- hw/rtl/sqr_queue.sv -----
// Two-entry queue between the front end and the back end.
module sqr_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sqr_pkg::sqr_item_t push_item,
    input  logic               pop,
    output logic               full,
    output logic               empty,
    output sqr_pkg::sqr_item_t head
);
    import sqr_pkg::*;

    sqr_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ----- hw/rtl/sqr_back.sv -----
// Back end: iterative float32 divide, rounding to float32 and stochastic rounding.
module sqr_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  sqr_pkg::sqr_item_t q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] rounded,
    output logic               out_of_range
);
    import sqr_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_NORM,
        ST_DIV,
        ST_RND,
        ST_FIX,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic               sign_reg;
    logic [23:0]        nm_reg;
    logic signed [9:0]  ne_reg;
    logic [23:0]        dm_reg;
    logic signed [9:0]  de_reg;
    logic [23:0]        draw_reg;
    logic [25:0]        rem_reg;
    logic [26:0]        quo_reg;
    logic [4:0]         cnt_reg;
    logic [23:0]        mant_reg;
    logic signed [10:0] exp_reg;
    logic [31:0]        res_reg;
    logic               flag_reg;
    logic               out_valid_reg;
    logic [31:0]        rounded_reg;
    logic               oor_reg;

    logic               ge;
    logic [25:0]        rem_sub;
    logic signed [10:0] x;
    logic signed [10:0] sh;
    logic [4:0]         sh_c;
    logic [58:0]        shifted;
    logic [26:0]        kept;
    logic               rbit;
    logic               stk;
    logic [26:0]        rnd_sum;
    logic [23:0]        mant_next;
    logic signed [10:0] exp_next;

    logic signed [10:0] neg_e;
    logic [71:0]        wide;
    logic [30:0]        ipart;
    logic [23:0]        tpart;
    logic               fstk;
    logic               frnd;
    logic               fracnz;
    logic [24:0]        ceil_v;
    logic               inc;
    logic [31:0]        fix_res;
    logic               fix_flag;

    assign q_pop        = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid    = out_valid_reg;
    assign rounded      = $signed(rounded_reg);
    assign out_of_range = oor_reg;

    always_comb
    begin
        ge      = (rem_reg >= {2'b00, dm_reg});
        rem_sub = ge ? (rem_reg - {2'b00, dm_reg}) : rem_reg;
    end

    always_comb
    begin
        x  = 11'(ne_reg) - 11'(de_reg) - 11'sd26;
        sh = quo_reg[26] ? 11'sd3 : 11'sd2;
        if (x + sh < -11'sd149)
            sh = -11'sd149 - x;
        sh_c    = (sh > 11'sd28) ? 5'd28 : sh[4:0];
        shifted = {quo_reg, 32'd0} >> sh_c;
        kept    = shifted[58:32];
        rbit    = shifted[31];
        stk     = (|shifted[30:0]) || (rem_reg != 26'd0);
        rnd_sum = kept + {26'd0, rbit & (stk | kept[0])};
        if (rnd_sum[24])
        begin
            mant_next = rnd_sum[24:1];
            exp_next  = x + sh + 11'sd1;
        end
        else
        begin
            mant_next = rnd_sum[23:0];
            exp_next  = x + sh;
        end
    end

    always_comb
    begin
        neg_e    = -exp_reg;
        wide     = '0;
        ipart    = '0;
        tpart    = '0;
        fstk     = 1'b0;
        frnd     = 1'b0;
        fracnz   = 1'b0;
        ceil_v   = '0;
        inc      = 1'b0;
        fix_res  = '0;
        fix_flag = 1'b0;
        if (!exp_reg[10])
        begin
            if (exp_reg >= 11'sd8)
            begin
                if (sign_reg && mant_reg == 24'h800000 && exp_reg == 11'sd8)
                    fix_res = 32'h80000000;
                else
                begin
                    fix_res  = sign_reg ? 32'h80000000 : 32'h7FFFFFFF;
                    fix_flag = 1'b1;
                end
            end
            else
            begin
                ipart   = {7'd0, mant_reg} << exp_reg[2:0];
                fix_res = sign_reg ? (32'd0 - {1'b0, ipart}) : {1'b0, ipart};
            end
        end
        else
        begin
            if (neg_e > 11'sd48)
                fstk = (mant_reg != 24'd0);
            else
            begin
                wide  = {mant_reg, 48'd0} >> neg_e[5:0];
                ipart = {7'd0, wide[71:48]};
                tpart = wide[47:24];
                fstk  = |wide[23:0];
                frnd  = wide[23] & ((|wide[22:0]) | tpart[0]);
            end
            if (!sign_reg)
            begin
                ceil_v  = {1'b0, tpart} + {24'd0, fstk};
                inc     = ({1'b0, draw_reg} < ceil_v);
                fix_res = {1'b0, ipart} + {31'd0, inc};
            end
            else
            begin
                // The fraction above the floor is rounded to float32 before the compare.
                fracnz  = (tpart != 24'd0) || fstk;
                ceil_v  = fracnz ? (25'h1000000 - {1'b0, tpart} - {24'd0, frnd}) : 25'd0;
                inc     = ({1'b0, draw_reg} < ceil_v);
                fix_res = 32'd0 - ({1'b0, ipart} + {31'd0, fracnz}) + {31'd0, inc};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        case (q_head.cls)
                            CLS_FINITE: state_reg <= ST_NORM;
                            default:    state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_NORM:
                begin
                    if (nm_reg[23] && dm_reg[23])
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (cnt_reg == 5'd0)
                        state_reg <= ST_RND;
                end
                ST_RND:
                begin
                    state_reg <= ST_FIX;
                end
                ST_FIX:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sign_reg <= q_head.sign;
                nm_reg   <= q_head.n_mant;
                ne_reg   <= q_head.n_exp;
                dm_reg   <= q_head.d_mant;
                de_reg   <= q_head.d_exp;
                draw_reg <= q_head.draw;
                case (q_head.cls)
                    CLS_NAN:
                    begin
                        res_reg  <= 32'd0;
                        flag_reg <= 1'b1;
                    end
                    CLS_SAT:
                    begin
                        res_reg  <= q_head.sign ? 32'h80000000 : 32'h7FFFFFFF;
                        flag_reg <= 1'b1;
                    end
                    default:
                    begin
                        res_reg  <= 32'd0;
                        flag_reg <= 1'b0;
                    end
                endcase
            end
            ST_NORM:
            begin
                if (!nm_reg[23])
                begin
                    nm_reg <= {nm_reg[22:0], 1'b0};
                    ne_reg <= ne_reg - 10'sd1;
                end
                if (!dm_reg[23])
                begin
                    dm_reg <= {dm_reg[22:0], 1'b0};
                    de_reg <= de_reg - 10'sd1;
                end
                rem_reg <= {2'b00, nm_reg};
                quo_reg <= '0;
                cnt_reg <= 5'd26;
            end
            ST_DIV:
            begin
                rem_reg <= {rem_sub[24:0], 1'b0};
                quo_reg <= {quo_reg[25:0], ge};
                cnt_reg <= cnt_reg - 5'd1;
            end
            ST_RND:
            begin
                mant_reg <= mant_next;
                exp_reg  <= exp_next;
            end
            ST_FIX:
            begin
                res_reg  <= fix_res;
                flag_reg <= fix_flag;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    rounded_reg <= res_reg;
                    oor_reg     <= flag_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- hw/rtl/stochastic_round_quantizer.sv -----
// Top level of the stochastic rounding quantizer with its register port.
// Each word is divided by the step size in float32, rounded to nearest even, and then
// rounded stochastically to int32 with a xoshiro256+ draw that advances once per word.
// An accepted word enters a two-entry queue at once; the back end then handles one word at
// a time: it takes the word from the queue, normalizes subnormal operands, runs the
// one-bit-per-cycle divider, and then rounds, converts and hands over the result, while
// NaN, zero and infinite cases go straight from the queue to the hand-over. A result that
// is not taken holds the back end until it is. The divider loop sets the throughput.
module stochastic_round_quantizer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sqr_pkg::ADDR_W-1:0]  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [31:0]                 value_bits,
    input  logic                        restart,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [31:0]          rounded,
    output logic                        out_of_range
);
    import sqr_pkg::*;

    logic [31:0] step_reg;
    sqr_seed_t   seed_reg;
    sqr_reg_t    reg_idx;
    logic        wr_en;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    sqr_item_t   q_item;
    sqr_item_t   q_head;

    assign pready  = 1'b1;
    assign reg_idx = sqr_reg_t'(paddr[5:3]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 32'h3F800000;
            seed_reg <= '{w0: 64'd1, w1: 64'd0, w2: 64'd0, w3: 64'd0};
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_STEP:  step_reg    <= pwdata[31:0];
                REG_SEED0: seed_reg.w0 <= pwdata;
                REG_SEED1: seed_reg.w1 <= pwdata;
                REG_SEED2: seed_reg.w2 <= pwdata;
                REG_SEED3: seed_reg.w3 <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_STEP:  prdata = {32'd0, step_reg};
            REG_SEED0: prdata = seed_reg.w0;
            REG_SEED1: prdata = seed_reg.w1;
            REG_SEED2: prdata = seed_reg.w2;
            REG_SEED3: prdata = seed_reg.w3;
            default:   prdata = '0;
        endcase
    end

    sqr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value_bits (value_bits),
        .restart    (restart),
        .step_bits  (step_reg),
        .seeds      (seed_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_item)
    );

    sqr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    sqr_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rounded      (rounded),
        .out_of_range (out_of_range)
    );

endmodule

// ----- test/sqr_checker.sv -----
// Checker for the stochastic rounding quantizer: tracks registers, predicts and compares words.
module sqr_checker
    import sqr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [63:0]         pwdata,
    input  logic                pready,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [31:0]         value_bits,
    input  logic                restart,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic signed [31:0]  rounded,
    input  logic                out_of_range,
    output int                  errors,
    output int                  pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic signed [31:0] value;
        logic               sat;
    } quantized_t;

    logic [31:0] step_bits;
    sqr_seed_t   seeds;
    logic [63:0] gen [4];
    quantized_t  expected_words [$];

    function automatic logic [63:0] draw_next();
        logic [63:0] result;
        logic [63:0] sh;
        result = gen[0] + gen[3];
        sh = gen[1] << 17;
        gen[2] = gen[2] ^ gen[0];
        gen[3] = gen[3] ^ gen[1];
        gen[1] = gen[1] ^ gen[2];
        gen[0] = gen[0] ^ gen[3];
        gen[2] = gen[2] ^ sh;
        gen[3] = (gen[3] << 45) | (gen[3] >> 19);
        return result;
    endfunction

    function automatic real f32_to_real(logic [31:0] f);
        real r;
        if (f[30:23] == 8'hFF)
        begin
            return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'b0});
        end
        if (f[30:23] == 8'h00)
        begin
            r = real'(f[22:0]) * (2.0 ** (-149));
            return f[31] ? -r : r;
        end
        return $bitstoreal({f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'b0});
    endfunction

    function automatic logic [31:0] real_to_f32(real r);
        logic [63:0] b;
        int          e;
        int          sh;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] res;
        b = $realtobits(r);
        if (b[62:0] == 63'b0)
        begin
            return {b[63], 31'b0};
        end
        e = int'(b[62:52]) - 1023;
        if (e > 127)
        begin
            return {b[63], 8'hFF, 23'b0};
        end
        sig = {11'b0, 1'b1, b[51:0]};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60)
        begin
            return {b[63], 31'b0};
        end
        kept = sig >> sh;
        rem = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (e >= -126)
        begin
            res = {1'b0, 8'(e + 127), kept[22:0]};
        end
        else
        begin
            res = {9'b0, kept[22:0]};
        end
        if (rem > half || (rem == half && kept[0]))
        begin
            res = res + 32'd1;
        end
        res[31] = b[63];
        return res;
    endfunction

    function automatic logic [31:0] divide_f32(logic [31:0] n, logic [31:0] d);
        logic n_nan;
        logic d_nan;
        logic n_inf;
        logic d_inf;
        logic sgn;
        n_nan = (n[30:0] > 31'h7F800000);
        d_nan = (d[30:0] > 31'h7F800000);
        n_inf = (n[30:0] == 31'h7F800000);
        d_inf = (d[30:0] == 31'h7F800000);
        sgn = n[31] ^ d[31];
        if (n_nan || d_nan || (n_inf && d_inf))
        begin
            return 32'h7FC00000;
        end
        if (d[30:0] == 31'b0)
        begin
            return (n[30:0] == 31'b0) ? 32'h7FC00000 : {sgn, 31'h7F800000};
        end
        if (n_inf)
        begin
            return {sgn, 31'h7F800000};
        end
        if (d_inf || n[30:0] == 31'b0)
        begin
            return {sgn, 31'b0};
        end
        return real_to_f32(f32_to_real(n) / f32_to_real(d));
    endfunction

    function automatic quantized_t quantize_word(logic [31:0] v, logic [63:0] r);
        quantized_t  q;
        logic [31:0] quot_bits;
        real         quot;
        real         fl;
        real         frac;
        real         draw;
        draw = real'(r[63:40]) * (2.0 ** (-24));
        quot_bits = divide_f32(v, step_bits);
        q.sat = 1'b0;
        if (quot_bits[30:23] == 8'hFF && quot_bits[22:0] != 23'b0)
        begin
            q.value = 32'sd0;
            q.sat = 1'b1;
            return q;
        end
        quot = f32_to_real(quot_bits);
        if (quot >= 8388608.0 || quot <= -8388608.0)
        begin
            fl = quot;
            frac = 0.0;
        end
        else
        begin
            fl = $floor(quot);
            frac = f32_to_real(real_to_f32(quot - fl));
        end
        if (fl >= 2147483648.0)
        begin
            q.value = 32'sh7FFFFFFF;
            q.sat = 1'b1;
        end
        else if (fl < -2147483648.0)
        begin
            q.value = 32'sh80000000;
            q.sat = 1'b1;
        end
        else
        begin
            q.value = 32'(longint'(fl) + ((draw < frac) ? 1 : 0));
        end
        return q;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        quantized_t got;
        quantized_t want;
        if (!rst_n)
        begin
            step_bits = 32'h3F800000;
            seeds = '{w0: 64'd1, w1: 64'd0, w2: 64'd0, w3: 64'd0};
            gen[0] = 64'd1;
            gen[1] = 64'd0;
            gen[2] = 64'd0;
            gen[3] = 64'd0;
            expected_words.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (sqr_reg_t'(paddr[5:3]))
                    REG_STEP:  step_bits = pwdata[31:0];
                    REG_SEED0: seeds.w0 = pwdata;
                    REG_SEED1: seeds.w1 = pwdata;
                    REG_SEED2: seeds.w2 = pwdata;
                    REG_SEED3: seeds.w3 = pwdata;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (restart)
                begin
                    gen[0] = seeds.w0;
                    gen[1] = seeds.w1;
                    gen[2] = seeds.w2;
                    gen[3] = seeds.w3;
                end
                expected_words.push_back(quantize_word(value_bits, draw_next()));
            end
            if (out_valid && out_ready)
            begin
                got.value = rounded;
                got.sat = out_of_range;
                if (expected_words.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("Unexpected word: rounded %0d out_of_range %0b",
                                 got.value, got.sat);
                    end
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("Mismatch: rounded %0d/%0d out_of_range %0b/%0b (exp/act)",
                                     want.value, got.value, want.sat, got.sat);
                        end
                    end
                end
            end
            pending = expected_words.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the stochastic rounding quantizer: stimulus, idling and verdict.
module tb_top;

    import sqr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 3000;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [31:0]        value_bits;
    logic               restart;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] rounded;
    logic               out_of_range;
    int                 errors;
    int                 pending;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 quiet_cycles;

    stochastic_round_quantizer i_dut
    (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .value_bits(value_bits), .restart(restart),
        .out_valid(out_valid), .out_ready(out_ready),
        .rounded(rounded), .out_of_range(out_of_range)
    );

    sqr_checker i_checker
    (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .value_bits(value_bits), .restart(restart),
        .out_valid(out_valid), .out_ready(out_ready),
        .rounded(rounded), .out_of_range(out_of_range),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(sqr_reg_t r, logic [63:0] v);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {r, 3'b000};
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (120) @(negedge clk);
    endtask

    task automatic send_word(logic [31:0] v, logic r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        value_bits = v;
        restart = r;
        #1;
        while (!in_ready)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] specials [14];
        specials = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                     32'h7FC00001, 32'hFFFFFFFF, 32'h00000001, 32'h807FFFFF,
                     32'h7F7FFFFF, 32'h4F000000, 32'hCF000000, 32'hCF000001,
                     32'h4B000000, 32'hCB7FFFFF};
        case ($urandom_range(9))
            0, 1: return $urandom;
            2: return specials[$urandom_range(13)];
            default: return {1'($urandom_range(1)), 8'($urandom_range(118, 158)),
                             23'($urandom)};
        endcase
    endfunction

    initial
    begin
        logic [31:0] unit_values [15];
        int          idle_set [4];
        int          stall_set [4];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        value_bits = '0;
        restart = 1'b0;
        out_ready = 1'b1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        idle_set = '{0, 67, 0, 21};
        stall_set = '{0, 0, 67, 21};
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        unit_values = '{32'h00000000, 32'h80000000, 32'h40200000, 32'hC0200000,
                        32'h7FC00000, 32'h7F800000, 32'hFF800000, 32'h7F7FFFFF,
                        32'h4F000000, 32'hCF000000, 32'h4AFFFFFF, 32'h00000001,
                        32'h807FFFFF, 32'h3F7FFFFF, 32'hBF7FFFFF};
        foreach (unit_values[k])
        begin
            send_word(unit_values[k], 1'b0);
        end
        drain();
        write_reg(REG_STEP, 64'h0);
        send_word(32'h00000000, 1'b1);
        send_word(32'h3F800000, 1'b0);
        send_word(32'hBF800000, 1'b0);
        send_word(32'hFFC00000, 1'b0);
        drain();
        write_reg(REG_STEP, 64'h00000001);
        send_word(32'h00000001, 1'b0);
        send_word(32'h80000003, 1'b0);
        drain();
        write_reg(REG_STEP, 64'hFF800000);
        send_word(32'h7F7FFFFF, 1'b0);
        drain();
        write_reg(REG_STEP, 64'h7FFFFFFF);
        send_word(32'h3F800000, 1'b0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(REG_STEP, (phase == 3) ? 64'($urandom)
                                : 64'({1'($urandom_range(1)), 8'($urandom_range(122, 132)),
                                       23'($urandom)}));
            write_reg(REG_SEED0, (phase == 1) ? 64'd0 : {$urandom, $urandom});
            write_reg(REG_SEED1, (phase == 1) ? 64'd0 : {$urandom, $urandom});
            write_reg(REG_SEED2, (phase == 1) ? 64'd0 : {$urandom, $urandom});
            write_reg(REG_SEED3, (phase == 1) ? 64'd0 : {$urandom, $urandom});
            send_idle_pct = idle_set[phase];
            recv_stall_pct = stall_set[phase];
            for (int k = 0; k < 100; k++)
            begin
                if (k == 50 && phase == 2)
                begin
                    drain();
                end
                send_word(pick_value(), (k == 0) || ($urandom_range(9) == 0));
                if (k % 25 == 24)
                begin
                    send_idle_pct = (send_idle_pct == 0) ? idle_set[phase] : 0;
                end
            end
            drain();
        end

        if (errors == 0 && pending == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
